// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker of the ring buffer deque.
// Holds only macro definitions; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RBD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define RBD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication that is also checked across reset.
`define RBD_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== hdl/rbd_pkg.sv =====
// Package for the ring buffer deque: sizes, command and status codes, stream field
// positions, pointer helpers and the controller/datapath interface structs. No dependencies.
`default_nettype none

package rbd_pkg;

    // Storage sizes.
    localparam int CAPACITY      = 16;
    localparam int ELEMENT_WIDTH = 32;
    localparam int PTR_W         = $clog2(CAPACITY);
    localparam int CNT_W         = $clog2(CAPACITY + 1);

    // Fixed field widths on the stream ports.
    localparam int COMMAND_W      = 2;
    localparam int PUSH_VALUE_W   = 32;
    localparam int POPPED_VALUE_W = 32;
    localparam int STATUS_W       = 2;
    localparam int ENTRY_COUNT_W  = 5;

    // Stream data layout, first field in the lowest bits, padded to whole bytes.
    localparam int S_DATA_BITS     = COMMAND_W + PUSH_VALUE_W;
    localparam int S_TDATA_W       = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int S_COMMAND_LSB   = 0;
    localparam int S_PUSH_LSB      = S_COMMAND_LSB + COMMAND_W;
    localparam int M_DATA_BITS     = POPPED_VALUE_W + STATUS_W + ENTRY_COUNT_W;
    localparam int M_TDATA_W       = ((M_DATA_BITS + 7) / 8) * 8;
    localparam int M_POPPED_LSB    = 0;
    localparam int M_STATUS_LSB    = M_POPPED_LSB + POPPED_VALUE_W;
    localparam int M_COUNT_LSB     = M_STATUS_LSB + STATUS_W;

    // Command codes.
    localparam logic [COMMAND_W-1:0] CMD_PUSH_BACK  = 2'd0;
    localparam logic [COMMAND_W-1:0] CMD_PUSH_FRONT = 2'd1;
    localparam logic [COMMAND_W-1:0] CMD_POP_BACK   = 2'd2;
    localparam logic [COMMAND_W-1:0] CMD_POP_FRONT  = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;    // a transaction is taken on the input channel
        logic load_now;  // result is known at acceptance; load the output register
        logic load_pop;  // memory read data is ready; load the output register
    } rbd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_ok;    // the offered command is a pop that will succeed
    } rbd_stat_t;

    // Step a ring pointer forward, wrapping from the last slot to zero.
    function automatic logic [PTR_W-1:0] step_forward(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    // Step a ring pointer backward, wrapping from zero to the last slot.
    function automatic logic [PTR_W-1:0] step_backward(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - PTR_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rbd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rbd_ctrl.sv =====
// Controller of the ring buffer deque: sequences acceptance, the memory read of a
// pop and the output valid flag. Depends on rbd_pkg.
`default_nettype none

module rbd_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    input  wire rbd_pkg::rbd_stat_t stat,
    output rbd_pkg::rbd_cmd_t     cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_POP_WAIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // The output register can take a result if empty or emptied in this cycle.
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;

    // Command decode for the datapath.
    always_comb begin
        cmd.accept   = s_tvalid && s_tready;
        cmd.load_now = cmd.accept && !stat.pop_ok;
        cmd.load_pop = (state_reg == ST_POP_WAIT);
    end

    // Next state and output valid.
    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (cmd.accept && stat.pop_ok) begin
                    state_next = ST_POP_WAIT;
                end
                if (cmd.load_now) begin
                    out_valid_next = 1'b1;
                end
            end
            ST_POP_WAIT: begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered output.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// ===== hdl/rbd_datapath.sv =====
// Datapath of the ring buffer deque: pointers, count, element store and result register.
// Depends on rbd_pkg and rbd_ram.
`default_nettype none

module rbd_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic [rbd_pkg::COMMAND_W-1:0]       command,
    input  wire logic [rbd_pkg::PUSH_VALUE_W-1:0]    push_value,
    input  wire rbd_pkg::rbd_cmd_t                   cmd,
    output rbd_pkg::rbd_stat_t                       stat,
    output logic      [rbd_pkg::POPPED_VALUE_W-1:0]  popped_value,
    output logic      [rbd_pkg::STATUS_W-1:0]        status,
    output logic      [rbd_pkg::ENTRY_COUNT_W-1:0]   entry_count
);

    logic [rbd_pkg::PTR_W-1:0] front_reg, front_next;
    logic [rbd_pkg::PTR_W-1:0] back_reg, back_next;
    logic [rbd_pkg::CNT_W-1:0] count_reg, count_next;

    logic [rbd_pkg::POPPED_VALUE_W-1:0] popped_reg, popped_next;
    logic [rbd_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic [rbd_pkg::CNT_W-1:0]          ocount_reg, ocount_next;

    logic                               is_push, is_full, is_empty;
    logic                               ram_we, ram_re;
    logic [rbd_pkg::PTR_W-1:0]          ram_waddr, ram_raddr;
    logic [rbd_pkg::ELEMENT_WIDTH-1:0]  ram_wdata, ram_rdata;
    logic [rbd_pkg::STATUS_W-1:0]       now_status;

    // Command classification against the current fill level.
    assign is_push     = (command == rbd_pkg::CMD_PUSH_BACK) ||
                         (command == rbd_pkg::CMD_PUSH_FRONT);
    assign is_full     = (count_reg == rbd_pkg::CNT_FULL);
    assign is_empty    = (count_reg == '0);
    assign stat.pop_ok = !is_push && !is_empty;
    assign ram_wdata   = rbd_pkg::ELEMENT_WIDTH'(push_value);

    // Pointer, count and memory access for the accepted command.
    always_comb begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = back_reg;
        ram_raddr  = front_reg;
        now_status = rbd_pkg::ST_DONE;
        if (is_push && is_full) begin
            now_status = rbd_pkg::ST_FULL;
        end else if (!is_push && is_empty) begin
            now_status = rbd_pkg::ST_EMPTY;
        end
        if (cmd.accept && now_status == rbd_pkg::ST_DONE) begin
            case (command)
                rbd_pkg::CMD_PUSH_BACK: begin
                    ram_we     = 1'b1;
                    ram_waddr  = back_reg;
                    back_next  = rbd_pkg::step_forward(back_reg);
                    count_next = count_reg + rbd_pkg::CNT_W'(1);
                end
                rbd_pkg::CMD_PUSH_FRONT: begin
                    ram_we     = 1'b1;
                    front_next = rbd_pkg::step_backward(front_reg);
                    ram_waddr  = front_next;
                    count_next = count_reg + rbd_pkg::CNT_W'(1);
                end
                rbd_pkg::CMD_POP_BACK: begin
                    ram_re     = 1'b1;
                    back_next  = rbd_pkg::step_backward(back_reg);
                    ram_raddr  = back_next;
                    count_next = count_reg - rbd_pkg::CNT_W'(1);
                end
                rbd_pkg::CMD_POP_FRONT: begin
                    ram_re     = 1'b1;
                    ram_raddr  = front_reg;
                    front_next = rbd_pkg::step_forward(front_reg);
                    count_next = count_reg - rbd_pkg::CNT_W'(1);
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Result register: loaded at acceptance for pushes and refusals, or from the
    // memory read data in the cycle after a successful pop is accepted.
    always_comb begin
        popped_next = popped_reg;
        status_next = status_reg;
        ocount_next = ocount_reg;
        if (cmd.load_now) begin
            popped_next = '0;
            status_next = now_status;
            ocount_next = count_next;
        end else if (cmd.load_pop) begin
            popped_next = rbd_pkg::POPPED_VALUE_W'(ram_rdata);
            status_next = rbd_pkg::ST_DONE;
            ocount_next = count_reg;
        end
    end

    // Control state with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end else begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    // Result payload, no reset needed.
    always_ff @(posedge aclk) begin
        popped_reg <= popped_next;
        status_reg <= status_next;
        ocount_reg <= ocount_next;
    end

    rbd_ram #(
        .WIDTH (rbd_pkg::ELEMENT_WIDTH),
        .DEPTH (rbd_pkg::CAPACITY)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign entry_count  = rbd_pkg::ENTRY_COUNT_W'(ocount_reg);

endmodule

`default_nettype wire

// ===== hdl/ring_buffer_deque.sv =====
// Top level of the ring buffer deque: joins controller and datapath to the streams.
// Depends on rbd_pkg, rbd_ctrl and rbd_datapath.
//
//   Channel | Direction | Fields (lowest bit first)
//   s_      | input     | command, push_value
//   m_      | output    | popped_value, status, entry_count
//
// A push, a refused push and a refused pop load the result into the output register at the
// edge that accepts the command.
// A successful pop loads the result from the registered read port of the element store.
// A new command is taken whenever the block is not waiting on a pop read and the output
// register is empty or being drained in the same cycle; a stalled output holds the input.
// Reset clears pointers, count and valid flags; the element store is not cleared.
`default_nettype none

module ring_buffer_deque (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [1:0] command, [33:2] push_value, [39:34] zero
    input  wire logic [rbd_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [31:0] popped_value, [33:32] status, [38:34] entry_count, [39] zero
    output logic      [rbd_pkg::M_TDATA_W-1:0]  m_tdata
);

    rbd_pkg::rbd_cmd_t  cmd;
    rbd_pkg::rbd_stat_t stat;

    logic [rbd_pkg::COMMAND_W-1:0]      command;
    logic [rbd_pkg::PUSH_VALUE_W-1:0]   push_value;
    logic [rbd_pkg::POPPED_VALUE_W-1:0] popped_value;
    logic [rbd_pkg::STATUS_W-1:0]       status;
    logic [rbd_pkg::ENTRY_COUNT_W-1:0]  entry_count;

    // Unpack the input transaction.
    assign command    = s_tdata[rbd_pkg::S_COMMAND_LSB +: rbd_pkg::COMMAND_W];
    assign push_value = s_tdata[rbd_pkg::S_PUSH_LSB +: rbd_pkg::PUSH_VALUE_W];

    rbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rbd_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .command      (command),
        .push_value   (push_value),
        .cmd          (cmd),
        .stat         (stat),
        .popped_value (popped_value),
        .status       (status),
        .entry_count  (entry_count)
    );

    // Pack the result transaction, padding with zeros.
    assign m_tdata = rbd_pkg::M_TDATA_W'({entry_count, status, popped_value});

endmodule

`default_nettype wire

// ===== hdl/rbd_checker.sv =====
// Port-level checker for the ring buffer deque, bound to the top level.
// Depends on rbd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rbd_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [rbd_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic [rbd_pkg::POPPED_VALUE_W-1:0] popped;
    logic [rbd_pkg::STATUS_W-1:0]       status;
    logic [rbd_pkg::ENTRY_COUNT_W-1:0]  count;
    logic [rbd_pkg::ENTRY_COUNT_W-1:0]  cap_count;
    logic                               empty_rsp;
    logic                               full_rsp;

    assign popped = m_tdata[rbd_pkg::M_POPPED_LSB +: rbd_pkg::POPPED_VALUE_W];
    assign status = m_tdata[rbd_pkg::M_STATUS_LSB +: rbd_pkg::STATUS_W];
    assign count  = m_tdata[rbd_pkg::M_COUNT_LSB +: rbd_pkg::ENTRY_COUNT_W];

    // Refusal flags of the presented result and the count of a full deque.
    assign cap_count = rbd_pkg::ENTRY_COUNT_W'(rbd_pkg::CAPACITY);
    assign empty_rsp = m_tvalid && (status == rbd_pkg::ST_EMPTY);
    assign full_rsp  = m_tvalid && (status == rbd_pkg::ST_FULL);

    // A stalled result transaction keeps its payload.
    `RBD_ASSERT_NXT(a_hold_payload, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))

    // A refused pop reports an empty deque and no data.
    `RBD_ASSERT_IMP(a_empty_result, aclk, aresetn, empty_rsp, popped == '0 && count == '0)

    // A refused push reports a deque filled to capacity.
    `RBD_ASSERT_IMP(a_full_result, aclk, aresetn, full_rsp, count == cap_count)

    // The reported count never exceeds the capacity.
    `RBD_ASSERT_IMP(a_count_range, aclk, aresetn, m_tvalid, count <= cap_count)

    // Reset leaves no result pending.
    `RBD_ASSERT_NXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_tvalid)

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
